### design/lsp_pkg.sv
// Shared types, constants and the delay table of the LED stacking and LFSR pattern block.
package lsp_pkg;

    localparam int unsigned SampleWidth = 10;
    localparam int unsigned LedWidth    = 8;
    localparam int unsigned DelayWidth  = 20;
    localparam int unsigned ChoiceWidth = 3;

    // Pattern modes.
    localparam logic MODE_STACK = 1'b0;
    localparam logic MODE_SHIFT = 1'b1;

    // Delay choice codes.
    localparam logic [ChoiceWidth-1:0] DELAY_100K = 3'd0;
    localparam logic [ChoiceWidth-1:0] DELAY_300K = 3'd1;
    localparam logic [ChoiceWidth-1:0] DELAY_500K = 3'd2;
    localparam logic [ChoiceWidth-1:0] DELAY_700K = 3'd3;
    localparam logic [ChoiceWidth-1:0] DELAY_900K = 3'd4;

    // Potentiometer thresholds between the delay bands.
    localparam logic [SampleWidth-1:0] THRESH_1 = 10'd205;
    localparam logic [SampleWidth-1:0] THRESH_2 = 10'd410;
    localparam logic [SampleWidth-1:0] THRESH_3 = 10'd615;
    localparam logic [SampleWidth-1:0] THRESH_4 = 10'd820;

    // Pattern restart values.
    localparam logic [LedWidth-1:0] MOVING_START = 8'h01;
    localparam logic [LedWidth-1:0] MOVING_TOP   = 8'h80;
    localparam logic [LedWidth-1:0] FILLED_START = 8'h00;
    localparam logic [LedWidth-1:0] FILLED_FULL  = 8'hFF;
    localparam logic [LedWidth-1:0] SHIFT_SEED   = 8'h39;

    typedef struct packed {
        logic [SampleWidth-1:0] adc_sample;
        logic                   adc_ok;
        logic                   button_next;
        logic                   button_prev;
    } lsp_item_t;

    typedef struct packed {
        logic [LedWidth-1:0]   led_pattern;
        logic [DelayWidth-1:0] step_delay;
        logic                  active_mode;
    } lsp_result_t;

    function automatic logic [DelayWidth-1:0] delay_cycles(input logic [ChoiceWidth-1:0] choice);
        logic [DelayWidth-1:0] cycles;
        case (choice)
            DELAY_100K: cycles = 20'd100000;
            DELAY_300K: cycles = 20'd300000;
            DELAY_500K: cycles = 20'd500000;
            DELAY_700K: cycles = 20'd700000;
            default:    cycles = 20'd900000;
        endcase
        return cycles;
    endfunction

endpackage

### design/lsp_delay_sel.sv
// Threshold compare that maps a potentiometer sample to a delay choice.
module lsp_delay_sel
    import lsp_pkg::*;
(
    input  logic [SampleWidth-1:0] adc_sample,
    output logic [ChoiceWidth-1:0] choice
);

    always_comb
    begin
        if (adc_sample < THRESH_1)
            choice = DELAY_100K;
        else if (adc_sample < THRESH_2)
            choice = DELAY_300K;
        else if (adc_sample < THRESH_3)
            choice = DELAY_500K;
        else if (adc_sample < THRESH_4)
            choice = DELAY_700K;
        else
            choice = DELAY_900K;
    end

endmodule

### design/lsp_step.sv
// Pattern state registers and the single-tick update of delay, mode and LED pattern.
module lsp_step
    import lsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  lsp_item_t   item,
    output lsp_result_t result
);

    logic [ChoiceWidth-1:0] choice_reg, choice_next, sample_choice;
    logic                   mode_reg, mode_next;
    logic                   last_next_reg, last_prev_reg;
    logic [LedWidth-1:0]    moving_reg, moving_next;
    logic [LedWidth-1:0]    filled_reg, filled_next;
    logic [LedWidth-1:0]    shift_reg, shift_next;

    logic                   edge_next, edge_prev, restart;
    logic [LedWidth-1:0]    moving_cur, filled_cur, shift_cur;
    logic [LedWidth-1:0]    next_pos, merged, shifted;
    logic                   merge;
    logic [LedWidth-1:0]    pattern;

    lsp_delay_sel u_delay_sel (
        .adc_sample (item.adc_sample),
        .choice     (sample_choice)
    );

    always_comb
    begin
        choice_next = item.adc_ok ? sample_choice : choice_reg;

        // A falling edge on either button toggles the mode; both together cancel out.
        edge_next = last_next_reg & ~item.button_next;
        edge_prev = last_prev_reg & ~item.button_prev;
        restart   = edge_next | edge_prev;
        mode_next = mode_reg ^ edge_next ^ edge_prev;

        moving_cur = restart ? MOVING_START : moving_reg;
        filled_cur = restart ? FILLED_START : filled_reg;
        shift_cur  = restart ? SHIFT_SEED   : shift_reg;

        next_pos = {moving_cur[LedWidth-2:0], 1'b0};
        merged   = filled_cur | moving_cur;
        merge    = (moving_cur == MOVING_TOP) || ((next_pos & filled_cur) != '0);
        shifted  = {shift_cur[LedWidth-2:0], shift_cur[5] ^ shift_cur[4]};

        moving_next = moving_cur;
        filled_next = filled_cur;
        shift_next  = shift_cur;

        if (mode_next == MODE_STACK)
        begin
            pattern = merged;
            if (merge)
            begin
                moving_next = MOVING_START;
                filled_next = (merged == FILLED_FULL) ? FILLED_START : merged;
            end
            else
            begin
                moving_next = next_pos;
            end
        end
        else
        begin
            shift_next = shifted;
            pattern    = shifted;
        end

        result.led_pattern = pattern;
        result.step_delay  = delay_cycles(choice_next);
        result.active_mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            choice_reg    <= DELAY_500K;
            mode_reg      <= MODE_STACK;
            last_next_reg <= 1'b1;
            last_prev_reg <= 1'b1;
            moving_reg    <= MOVING_START;
            filled_reg    <= FILLED_START;
            shift_reg     <= SHIFT_SEED;
        end
        else if (advance)
        begin
            choice_reg    <= choice_next;
            mode_reg      <= mode_next;
            last_next_reg <= item.button_next;
            last_prev_reg <= item.button_prev;
            moving_reg    <= moving_next;
            filled_reg    <= filled_next;
            shift_reg     <= shift_next;
        end
    end

endmodule

### design/led_stack_and_lfsr_pattern.sv
// Top level of the LED stacking and LFSR pattern generator with its input and result registers.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_stall   adc_sample, adc_ok, button_next, button_prev
//   output   out_valid/out_stall led_pattern, step_delay, active_mode
//
// Every tick transaction passes an input register and then a result register. Its result is
// offered once the result register has taken it from the input register.
// One transaction can be accepted in every cycle in which in_stall is low.
// The pattern state advances only when the input register hands its tick to the result
// register, which keeps the order of ticks exact under any stall pattern.
// Reset (rst_n low, asynchronous) empties both registers and restores the pattern state:
// delay choice DELAY_500K, stacking mode, both buttons released, pattern restarted.
// A stalled result holds; the input register then fills and in_stall rises.
module led_stack_and_lfsr_pattern
    import lsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SampleWidth-1:0] adc_sample,
    input  logic                   adc_ok,
    input  logic                   button_next,
    input  logic                   button_prev,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LedWidth-1:0]    led_pattern,
    output logic [DelayWidth-1:0]  step_delay,
    output logic                   active_mode
);

    // Input register stage.
    logic        item_valid_reg;
    lsp_item_t   item_reg;

    // Result register stage.
    logic        res_valid_reg;
    lsp_result_t res_reg;

    lsp_result_t step_result;
    logic        res_free;
    logic        advance;
    logic        in_take;

    // The result register can take a new tick when empty or when its transaction completes.
    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = item_valid_reg && res_free;
    assign in_stall = item_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    lsp_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.adc_sample  <= adc_sample;
            item_reg.adc_ok      <= adc_ok;
            item_reg.button_next <= button_next;
            item_reg.button_prev <= button_prev;
        end
        if (advance)
            res_reg <= step_result;
    end

    assign out_valid   = res_valid_reg;
    assign led_pattern = res_reg.led_pattern;
    assign step_delay  = res_reg.step_delay;
    assign active_mode = res_reg.active_mode;

endmodule
